### rtl/core/xor_sprite_blitter_top_assert.svh
// Assertion macros for the XOR sprite blitter.
`ifndef XOR_SPRITE_BLITTER_TOP_ASSERT_SVH
`define XOR_SPRITE_BLITTER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define XSB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define XSB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/xsb_pkg.sv
// Shared types, constants and address helper for the XOR sprite blitter.
`timescale 1ns / 1ps

package xsb_pkg;

   localparam int unsigned SCREEN_BYTES = 6144;
   localparam int unsigned SCREEN_LINES = 192;
   localparam int unsigned ADDR_W       = 13;
   localparam logic [4:0]  LAST_COL     = 5'd31;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_DRAW
   } state_type;

   typedef struct packed {
      logic              re;
      logic [ADDR_W-1:0] raddr;
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [7:0]        wdata;
   } mem_req_type;

   // Interleaved screen layout: third, pixel row in cell, cell row.
   function automatic logic [ADDR_W-1:0] line_base(input logic [7:0] y);
      line_base = {y[7:6], y[2:0], y[5:3], 5'b00000};
   endfunction

endpackage

### rtl/core/xsb_screen_ram.sv
// Frame buffer memory: one write port, one registered read port.
`timescale 1ns / 1ps

module xsb_screen_ram
   import xsb_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output logic [7:0]  rd_data
);

   logic [7:0] mem_array [SCREEN_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_array[mem_req.waddr] <= mem_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rd_data_ff <= mem_array[mem_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/xsb_ctrl.sv
// Sequencer: clearing pass, byte reads and pipelined read-modify-write draws.
`timescale 1ns / 1ps

module xsb_ctrl
   import xsb_pkg::*;
#(
   parameter int unsigned SPRITE_ROWS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_cmd,
   input  logic [7:0]        req_pos_x,
   input  logic [7:0]        req_pos_y,
   input  logic [63:0]       req_sprite_bits,
   input  logic [ADDR_W-1:0] req_read_addr,
   output logic              rsp_valid,
   output logic [7:0]        rsp_read_data,
   output mem_req_type       mem_req,
   input  logic [7:0]        rd_data
);

   localparam int unsigned SLOT_LAST = 2 * SPRITE_ROWS;
   localparam int unsigned SLOT_W    = $clog2(SLOT_LAST + 1);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [7:0]        x_ff, x_in;
   logic [7:0]        y_ff, y_in;
   logic [63:0]       bits_ff, bits_in;
   logic              oob_ff, oob_in;
   logic              pend_we_ff, pend_we_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic [7:0]        pend_val_ff, pend_val_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              slot_last;
   logic [2:0]        row_idx;
   logic              side;
   logic [7:0]        row_byte;
   logic [8:0]        line;
   logic [4:0]        col;
   logic [4:0]        col_sel;
   logic [2:0]        sh;
   logic [15:0]       shifted;
   logic              slot_ok;
   logic [ADDR_W-1:0] slot_addr;
   logic [7:0]        slot_val;

   assign accept    = start && (state_ff == ST_IDLE);
   assign slot_last = (slot_ff == SLOT_W'(SLOT_LAST));

   // Even slot: left byte of row, odd slot: spill byte of the same row.
   assign row_idx   = 3'(slot_ff >> 1);
   assign side      = slot_ff[0];
   assign row_byte  = bits_ff[{row_idx, 3'b000} +: 8];
   assign line      = {1'b0, y_ff} + {6'b0, row_idx};
   assign col       = x_ff[7:3];
   assign sh        = x_ff[2:0];
   assign col_sel   = side ? (col + 5'd1) : col;
   assign shifted   = {row_byte, 8'h00} >> sh;
   assign slot_val  = side ? shifted[7:0] : shifted[15:8];
   assign slot_addr = line_base(line[7:0]) | {{(ADDR_W-5){1'b0}}, col_sel};
   assign slot_ok   = !slot_last && (line < 9'(SCREEN_LINES))
                      && (!side || ((sh != 3'd0) && (col != LAST_COL)));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == ADDR_W'(SCREEN_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = req_cmd ? ST_READ : ST_DRAW;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         ST_DRAW: begin
            if (slot_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      mem_req      = '0;
      clr_addr_in  = clr_addr_ff;
      slot_in      = slot_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      bits_in      = bits_ff;
      oob_in       = oob_ff;
      pend_we_in   = 1'b0;
      pend_addr_in = slot_addr;
      pend_val_in  = slot_val;
      rsp_valid_in = 1'b0;
      rsp_data_in  = 8'h00;
      case (state_ff)
         ST_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = clr_addr_ff;
            mem_req.wdata = 8'h00;
            clr_addr_in   = clr_addr_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               x_in          = req_pos_x;
               y_in          = req_pos_y;
               bits_in       = req_sprite_bits;
               slot_in       = '0;
               oob_in        = (req_read_addr >= ADDR_W'(SCREEN_BYTES));
               mem_req.re    = req_cmd && (req_read_addr < ADDR_W'(SCREEN_BYTES));
               mem_req.raddr = req_read_addr;
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = oob_ff ? 8'h00 : rd_data;
         end
         ST_DRAW: begin
            // Read this slot's byte while writing back the previous one.
            mem_req.re    = slot_ok;
            mem_req.raddr = slot_addr;
            mem_req.we    = pend_we_ff;
            mem_req.waddr = pend_addr_ff;
            mem_req.wdata = rd_data ^ pend_val_ff;
            pend_we_in    = slot_ok;
            slot_in       = slot_ff + SLOT_W'(1);
            rsp_valid_in  = slot_last;
         end
         default: begin
            mem_req = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         pend_we_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         pend_we_ff   <= pend_we_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      bits_ff      <= bits_in;
      oob_ff       <= oob_in;
      pend_addr_ff <= pend_addr_in;
      pend_val_ff  <= pend_val_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

### rtl/core/xor_sprite_blitter_top.sv
// Top level of the XOR sprite blitter over an interleaved 256x192 frame buffer.
`timescale 1ns / 1ps
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  ------------------------------
//  request   req_cmd req_pos_x req_pos_y             beat taken when start && !busy
//            req_sprite_bits req_read_addr
//  response  rsp_read_data                           one-cycle strobe rsp_valid
//
//  A draw beat steps through its frame buffer byte slots, one slot per cycle,
//  each slot read while the previous slot is written back over the single
//  memory port pair; its response is registered after the last slot. A read
//  beat's byte is registered in the memory, then in the response register.
//  After reset a clearing pass writes all 6144 bytes, one per cycle, with busy
//  held high until the pass ends. The receiver cannot stall: every response
//  is a single-cycle strobe.

module xor_sprite_blitter_top
   import xsb_pkg::*;
#(
   parameter int unsigned SPRITE_ROWS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_cmd,
   input  logic [7:0]        req_pos_x,
   input  logic [7:0]        req_pos_y,
   input  logic [63:0]       req_sprite_bits,
   input  logic [ADDR_W-1:0] req_read_addr,
   output logic              rsp_valid,
   output logic [7:0]        rsp_read_data
);

`include "xor_sprite_blitter_top_assert.svh"

   mem_req_type mem_req;
   logic [7:0]  rd_data;

   // Sequencer owns all control; the memory only stores and returns bytes.
   xsb_ctrl #(
      .SPRITE_ROWS (SPRITE_ROWS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_sprite_bits (req_sprite_bits),
      .req_read_addr   (req_read_addr),
      .rsp_valid       (rsp_valid),
      .rsp_read_data   (rsp_read_data),
      .mem_req         (mem_req),
      .rd_data         (rd_data)
   );

   xsb_screen_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // An accepted beat keeps the block busy in the following cycle.
   `XSB_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept without busy")
   // A response always follows a cycle of work.
   `XSB_ASSERT_NOW(a_rsp_after_work, clock, reset, rsp_valid, $past(busy), "stray response")
   // Responses never come back to back.
   `XSB_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "double response")
   // The frame buffer is only written while work is in flight.
   `XSB_ASSERT_NOW(a_write_busy, clock, reset, mem_req.we, busy, "write while idle")

endmodule

### dv/tb_xor_sprite_blitter_top.sv
// Self-checking testbench for the XOR sprite blitter top level.
`timescale 1ns / 1ps

module tb_xor_sprite_blitter_top
   import xsb_pkg::*;
();

   // Command codes on req_cmd.
   localparam logic CMD_DRAW = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Layout and run constants.
   localparam int unsigned COLS         = 32;
   localparam int unsigned ROWS         = 8;
   localparam int unsigned RANDOM_BEATS = 1100;
   localparam int unsigned DRAIN_CYCLES = 24;
   localparam int unsigned CYCLE_LIMIT  = 400000;  // clear pass + ~1150 slow beats, many times over

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_cmd = CMD_DRAW;
   logic [7:0]        req_pos_x = '0;
   logic [7:0]        req_pos_y = '0;
   logic [63:0]       req_sprite_bits = '0;
   logic [ADDR_W-1:0] req_read_addr = '0;
   logic              rsp_valid;
   logic [7:0]        rsp_read_data;

   // Shadow frame buffer, cleared like the block's after reset.
   logic [7:0]  shadow_screen [0:SCREEN_BYTES-1];
   // Response bytes still owed by the block, oldest first.
   logic [7:0]  owed_bytes [$];
   logic [7:0]  owed_front;

   int unsigned failures    = 0;
   int unsigned draw_beats  = 0;
   int unsigned read_beats  = 0;
   int unsigned rsp_checked = 0;
   int unsigned cycle_count = 0;
   bit          steady      = 1'b0;   // suppress sender gaps while set
   logic [7:0]  last_x      = '0;
   logic [7:0]  last_y      = '0;

   xor_sprite_blitter_top #(
      .SPRITE_ROWS(ROWS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_sprite_bits (req_sprite_bits),
      .req_read_addr   (req_read_addr),
      .rsp_valid       (rsp_valid),
      .rsp_read_data   (rsp_read_data)
   );

   always #6 clock = ~clock;

   // Watchdog: a hung handshake must still end the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Byte offset of pixel line y, byte column col in the interleaved layout:
   // screen third from y[7:6], pixel row inside the cell from y[2:0],
   // cell row from y[5:3].
   function automatic logic [ADDR_W-1:0] screen_offset(input int unsigned y,
                                                       input int unsigned col);
      int unsigned offset;
      offset = ((y / 64) * 2048) + ((y % 8) * 256) + (((y / 8) % 8) * 32) + col;
      return offset[ADDR_W-1:0];
   endfunction

   // XOR one sprite into the shadow screen, clipping below line 191 and
   // past column 31.
   task automatic paint_sprite(input logic [7:0] x, input logic [7:0] y,
                               input logic [63:0] bits);
      int unsigned col;
      int unsigned shift;
      int unsigned line;
      logic [7:0]  row_byte;
      logic [15:0] spread;
      col   = x / 8;
      shift = x % 8;
      for (int r = 0; r < ROWS; r++) begin
         line     = y + r;
         row_byte = bits[8*r +: 8];
         // Place the row at the top of a 16-bit window, then slide it right.
         spread   = {row_byte, 8'h00} >> shift;
         if (line < SCREEN_LINES) begin
            shadow_screen[screen_offset(line, col)] ^= spread[15:8];
            if (shift != 0 && col + 1 < COLS)
               shadow_screen[screen_offset(line, col + 1)] ^= spread[7:0];
         end
      end
   endtask

   // Present one beat, hold it until the block takes it, then log what it owes.
   // Start stays high on return so back-to-back beats need no re-raise.
   task automatic send_beat(input logic cmd, input logic [7:0] x, input logic [7:0] y,
                            input logic [63:0] bits, input logic [ADDR_W-1:0] addr);
      int unsigned gap;
      if (!steady && $urandom_range(99) < 21) begin
         start <= 1'b0;
         gap = $urandom_range(1, 24);
         repeat (gap) @(posedge clock);
      end
      req_cmd         <= cmd;
      req_pos_x       <= x;
      req_pos_y       <= y;
      req_sprite_bits <= bits;
      req_read_addr   <= addr;
      start           <= 1'b1;
      do @(posedge clock); while (busy);
      if (cmd == CMD_DRAW) begin
         paint_sprite(x, y, bits);
         owed_bytes.push_back(8'h00);
         draw_beats++;
         last_x = x;
         last_y = y;
      end else begin
         owed_bytes.push_back(addr < SCREEN_BYTES ? shadow_screen[addr] : 8'h00);
         read_beats++;
      end
   endtask

   // Drop start and hold off until every owed response has come back.
   task automatic drain_responses();
      start <= 1'b0;
      while (owed_bytes.size() != 0) @(posedge clock);
   endtask

   function automatic logic [63:0] random_sprite();
      return {$urandom, $urandom};
   endfunction

   // Directed beats: empty screen, corner and edge placements, clipping,
   // aligned and shifted rows, out-of-range reads.
   task automatic test_directed_corners();
      send_beat(CMD_READ, 8'd0, 8'd0, '0, 13'd0);
      send_beat(CMD_READ, 8'd0, 8'd0, '0, 13'd6143);
      // Aligned full block at the top-left corner, read_addr ignored on a draw.
      send_beat(CMD_DRAW, 8'd0, 8'd0, {64{1'b1}}, {ADDR_W{1'b1}});
      send_beat(CMD_READ, 8'd0, 8'd0, '0, screen_offset(0, 0));
      send_beat(CMD_READ, 8'd0, 8'd0, '0, screen_offset(7, 0));
      // Shifted by three: bits spill into the next column.
      send_beat(CMD_DRAW, 8'd3, 8'd0, 64'h8001_C003_E007_F00F, '0);
      send_beat(CMD_READ, 8'd0, 8'd0, '0, screen_offset(0, 0));
      send_beat(CMD_READ, 8'd0, 8'd0, '0, screen_offset(3, 1));
      // Rightmost column with the largest shift: the spill is clipped.
      send_beat(CMD_DRAW, 8'd255, 8'd100, {64{1'b1}}, '0);
      send_beat(CMD_READ, 8'd0, 8'd0, '0, screen_offset(100, 31));
      send_beat(CMD_READ, 8'd0, 8'd0, '0, screen_offset(107, 31));
      // Bottom edge: only rows on lines up to 191 land.
      send_beat(CMD_DRAW, 8'd9, 8'd188, 64'hA5A5_5A5A_C3C3_3C3C, '0);
      send_beat(CMD_READ, 8'd0, 8'd0, '0, screen_offset(191, 1));
      send_beat(CMD_READ, 8'd0, 8'd0, '0, screen_offset(191, 2));
      // Entirely below the screen: nothing changes.
      send_beat(CMD_DRAW, 8'd64, 8'd192, {64{1'b1}}, '0);
      send_beat(CMD_DRAW, 8'd200, 8'd255, {64{1'b1}}, '0);
      // Across a screen-third boundary.
      send_beat(CMD_DRAW, 8'd130, 8'd60, 64'hFEDC_BA98_7654_3210, '0);
      send_beat(CMD_READ, 8'd0, 8'd0, '0, screen_offset(63, 16));
      send_beat(CMD_READ, 8'd0, 8'd0, '0, screen_offset(64, 17));
      // Addresses past the frame buffer read as zero.
      send_beat(CMD_READ, 8'd0, 8'd0, '0, 13'd6144);
      send_beat(CMD_READ, 8'd0, 8'd0, '0, 13'd7000);
      send_beat(CMD_READ, 8'd255, 8'd255, {64{1'b1}}, 13'd8191);
      drain_responses();
   endtask

   // Random mix of draws and reads; most reads target the area of the last
   // draw so that overlapping XORs are observed.
   task automatic test_random_mix();
      logic              cmd;
      logic [7:0]        x;
      logic [7:0]        y;
      logic [ADDR_W-1:0] addr;
      int unsigned       pick;
      int unsigned       line;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         // Hold a long stretch with no sender gaps.
         steady = (n >= 400 && n < 650);
         cmd  = $urandom_range(1) ? CMD_READ : CMD_DRAW;
         x    = 8'($urandom_range(255));
         pick = $urandom_range(99);
         if (pick < 80)      y = 8'($urandom_range(SCREEN_LINES - 1));
         else if (pick < 90) y = 8'($urandom_range(SCREEN_LINES - 1, SCREEN_LINES - ROWS));
         else                y = 8'($urandom_range(255, SCREEN_LINES));
         addr = ADDR_W'($urandom_range((1 << ADDR_W) - 1));
         if (cmd == CMD_READ) begin
            pick = $urandom_range(99);
            line = last_y + $urandom_range(ROWS - 1);
            if (pick < 60 && line < SCREEN_LINES)
               addr = screen_offset(line, (last_x / 8 + $urandom_range(1)) % COLS);
            else if (pick < 90)
               addr = ADDR_W'($urandom_range(SCREEN_BYTES - 1));
         end
         send_beat(cmd, x, y, random_sprite(), addr);
         // Pause now and then until the block has answered everything.
         if (n % 250 == 249)
            drain_responses();
      end
      steady = 1'b0;
      drain_responses();
   endtask

   // Compare each response strobe with the oldest owed byte.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (owed_bytes.size() == 0) begin
            $error("unexpected response: read_data actual %0h", rsp_read_data);
            failures++;
         end else begin
            owed_front = owed_bytes.pop_front();
            rsp_checked++;
            if (rsp_read_data !== owed_front) begin
               $error("read_data mismatch: expected %0h, actual %0h",
                      owed_front, rsp_read_data);
               failures++;
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < SCREEN_BYTES; i++)
         shadow_screen[i] = 8'h00;
      // Hold reset at the start, then release it; the clearing pass runs behind busy.
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_corners();
      test_random_mix();

      // Let any stray strobe show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (owed_bytes.size() != 0) begin
         $error("%0d responses never arrived", owed_bytes.size());
         failures++;
      end

      $display("covered %0d draw beats and %0d read beats with corner and clipped placements",
               draw_beats, read_beats);
      $display("checked %0d responses, %0d mismatches", rsp_checked, failures);
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### files.f
+incdir+rtl/core
rtl/core/xsb_pkg.sv
rtl/core/xsb_screen_ram.sv
rtl/core/xsb_ctrl.sv
rtl/core/xor_sprite_blitter_top.sv
dv/tb_xor_sprite_blitter_top.sv
